// ----- hdl/dijkstra_shortest_paths_unit_macros.svh -----
// Assertion macros shared by the shortest path unit.
`ifndef DIJKSTRA_SHORTEST_PATHS_UNIT_MACROS_SVH
`define DIJKSTRA_SHORTEST_PATHS_UNIT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define DSP_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define DSP_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hdl/dsp_pkg.sv -----
// Shared constants and types for the shortest path unit.
`default_nettype none
package dsp_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 256;
   localparam int VtxW   = 7;
   localparam int EpW    = 8;
   localparam int WgtW   = 16;
   localparam int DistW  = 22;
   localparam int TabW   = 23;
   localparam int VIdxW  = $clog2(MaxVertices);
   localparam int EIdxW  = $clog2(MaxEdges);
   localparam int FillW  = EIdxW + 1;
   localparam int EdgeW  = 2 * EpW + WgtW;
   localparam logic [TabW-1:0] DistNone = 23'h7FFFFF;
   localparam logic [TabW-1:0] DistSat  = 23'h3FFFFF;
   localparam logic [VtxW-1:0] MaxVtx   = 7'(MaxVertices);
   localparam logic [0:0] CsrVertexCount = 1'b0;
   localparam logic [0:0] CsrStartVertex = 1'b1;
   localparam logic CmdAdd = 1'b0;
   localparam logic CmdRun = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/dijkstra_shortest_paths_unit.sv -----
// Top level of the single-source shortest path unit.
// Usage: pulse start with command and edge fields while busy is low.
// An add (command 0) stores one undirected edge in the edge memory if its
// endpoints are valid and the memory is not full; the unit never raises busy
// for it, so adds may stream each cycle. A run (command 1) raises busy from
// the next cycle and computes shortest distances from start_vertex. It first
// clears the distance memory. Each settling round scans the vertex count
// through the distance memory, then walks every stored edge through the edge
// memory with a read-modify-write of the distance memory. Results then leave
// on rsp_valid in ascending vertex order, rsp_last_result on the final one;
// the receiver cannot stall, so each result transfer happens in the cycle it
// is shown. busy is low in the cycle the last result is shown. Reset clears
// the edge count, the registers to 64 and 1, and the control state; memory
// contents need no clearing. Write the csr registers only while the unit is
// idle.
`default_nettype none
module dijkstra_shortest_paths_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_command,
   input  wire logic [dsp_pkg::EpW-1:0]   req_endpoint_a,
   input  wire logic [dsp_pkg::EpW-1:0]   req_endpoint_b,
   input  wire logic [dsp_pkg::WgtW-1:0]  req_edge_weight,
   output logic                           rsp_valid,
   output logic [dsp_pkg::VtxW-1:0]       rsp_vertex_number,
   output logic [dsp_pkg::DistW-1:0]      rsp_path_distance,
   output logic                           rsp_last_result,
   input  wire logic                      csr_write,
   input  wire logic [0:0]                csr_index,
   input  wire logic [dsp_pkg::VtxW-1:0]  csr_data
);
   import dsp_pkg::*;
`include "dijkstra_shortest_paths_unit_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SCAN, S_SCAN_END, S_EREAD, S_EWAIT, S_DREAD, S_DWRITE,
      S_OREAD, S_OWAIT, S_OEMIT
   } state_type;

   state_type               state_ff;
   logic [VtxW-1:0]         vcount_ff, start_ff;
   logic [FillW-1:0]        fill_ff;
   logic [VtxW-1:0]         n_ff;
   logic [VtxW-1:0]         idx_ff;          // scan / init / output index
   logic [EIdxW:0]          eidx_ff;
   logic [MaxVertices-1:0]  settled_ff;
   logic [TabW-1:0]         best_ff;
   logic [VIdxW-1:0]        u_ff;
   logic                    found_ff;
   logic [VIdxW-1:0]        other_ff;
   logic [TabW-1:0]         nd_ff;
   logic                    rlx_ff;
   logic                    scan_vld_ff;
   logic [VIdxW-1:0]        scan_i_ff;
   logic                    pend_ff;          // held result waiting for next
   logic [VtxW-1:0]         pend_v_ff;
   logic [DistW-1:0]        pend_d_ff;

   logic [EdgeW-1:0]        edge_mem [MaxEdges];
   logic [TabW-1:0]         dist_mem [MaxVertices];
   logic [EdgeW-1:0]        edge_rd_ff;
   logic [TabW-1:0]         dist_rd_ff;

   logic [VtxW-1:0]         n_live;
   logic                    add_ok;
   logic                    accept;
   logic                    dwe;
   logic [VIdxW-1:0]        dwa, dra;
   logic [TabW-1:0]         dwd;
   logic [EpW-1:0]          ea, eb;
   logic [WgtW-1:0]         ew;
   logic                    e_ok;
   logic [TabW:0]           sum;
   logic                    report_ok;
   logic                    emit_mid;
   logic                    emit_last;

   assign n_live = (vcount_ff > MaxVtx) ? MaxVtx : vcount_ff;
   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign add_ok = (req_endpoint_a != '0) && (req_endpoint_b != '0)
                   && (req_endpoint_a <= EpW'(n_live)) && (req_endpoint_b <= EpW'(n_live))
                   && (fill_ff < FillW'(MaxEdges));
   assign {ea, eb, ew} = edge_rd_ff;
   assign e_ok = (ea != '0) && (eb != '0) && (ea <= EpW'(n_ff)) && (eb <= EpW'(n_ff));
   assign sum = (TabW+1)'(best_ff) + (TabW+1)'(ew);

   // output phase: vertex under test is reportable
   assign report_ok = (idx_ff < n_ff) && (idx_ff != start_ff - 7'd1)
                      && (dist_rd_ff != DistNone);
   assign emit_mid  = (state_ff == S_OEMIT) && report_ok && pend_ff;
   assign emit_last = ((state_ff == S_OEMIT) && (idx_ff + 7'd1 >= n_ff) && !report_ok
                       && pend_ff)
                      || ((state_ff == S_OREAD) && (idx_ff >= n_ff));

   always_ff @(posedge clock) begin
      if (accept && req_command == CmdAdd && add_ok) begin
         edge_mem[fill_ff[EIdxW-1:0]] <= {req_endpoint_a, req_endpoint_b, req_edge_weight};
      end
      edge_rd_ff <= edge_mem[eidx_ff[EIdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dwe) begin
         dist_mem[dwa] <= dwd;
      end
      dist_rd_ff <= dist_mem[dra];
   end

   // distance memory port selection
   always_comb begin
      dwe = 1'b0;
      dwa = other_ff;
      dwd = nd_ff;
      dra = idx_ff[VIdxW-1:0];
      case (state_ff)
         S_INIT: begin
            dwe = 1'b1;
            dwa = idx_ff[VIdxW-1:0];
            dwd = (idx_ff == start_ff - 7'd1) ? '0 : DistNone;
         end
         S_DREAD: dra = other_ff;
         S_DWRITE: dwe = rlx_ff && (nd_ff < dist_rd_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         vcount_ff   <= 7'd64;
         start_ff    <= 7'd1;
         fill_ff     <= '0;
         rsp_valid   <= 1'b0;
         pend_ff     <= 1'b0;
         scan_vld_ff <= 1'b0;
         settled_ff  <= '0;
      end else begin
         rsp_valid <= emit_mid || emit_last;
         if (emit_mid || emit_last) begin
            rsp_vertex_number <= pend_v_ff;
            rsp_path_distance <= pend_d_ff;
            rsp_last_result   <= emit_last;
         end
         if (csr_write) begin
            case (csr_index)
               CsrVertexCount: vcount_ff <= csr_data;
               CsrStartVertex: start_ff  <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && req_command == CmdAdd && add_ok) begin
                  fill_ff <= fill_ff + FillW'(1);
               end
               if (accept && req_command == CmdRun && start_ff != '0
                   && start_ff <= n_live) begin
                  n_ff       <= n_live;
                  idx_ff     <= '0;
                  settled_ff <= '0;
                  state_ff   <= S_INIT;
               end
            end
            S_INIT: begin
               if (idx_ff == MaxVtx - 7'd1) begin
                  idx_ff      <= '0;
                  best_ff     <= DistNone;
                  found_ff    <= 1'b0;
                  scan_vld_ff <= 1'b0;
                  state_ff    <= S_SCAN;
               end else begin
                  idx_ff <= idx_ff + 7'd1;
               end
            end
            S_SCAN: begin
               // read data arrives in the cycle after its address
               scan_vld_ff <= (idx_ff < n_ff);
               scan_i_ff   <= idx_ff[VIdxW-1:0];
               if (scan_vld_ff && !settled_ff[scan_i_ff] && dist_rd_ff < best_ff) begin
                  best_ff  <= dist_rd_ff;
                  u_ff     <= scan_i_ff;
                  found_ff <= 1'b1;
               end
               if (idx_ff >= n_ff) begin
                  state_ff <= S_SCAN_END;
               end else begin
                  idx_ff <= idx_ff + 7'd1;
               end
            end
            S_SCAN_END: begin
               scan_vld_ff <= 1'b0;
               if (found_ff || (scan_vld_ff && !settled_ff[scan_i_ff]
                                && dist_rd_ff < best_ff)) begin
                  if (!found_ff || (scan_vld_ff && !settled_ff[scan_i_ff]
                                    && dist_rd_ff < best_ff)) begin
                     best_ff <= dist_rd_ff;
                     u_ff    <= scan_i_ff;
                     settled_ff[scan_i_ff] <= 1'b1;
                  end else begin
                     settled_ff[u_ff] <= 1'b1;
                  end
                  eidx_ff  <= '0;
                  state_ff <= S_EREAD;
               end else begin
                  idx_ff   <= '0;
                  pend_ff  <= 1'b0;
                  state_ff <= S_OREAD;
               end
            end
            S_EREAD: begin
               if (eidx_ff >= (EIdxW+1)'(fill_ff)) begin
                  idx_ff   <= '0;
                  best_ff  <= DistNone;
                  found_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_EWAIT;
               end
            end
            S_EWAIT: begin
               if (e_ok && ea == EpW'(u_ff) + 8'd1) begin
                  other_ff <= VIdxW'(eb - 8'd1);
                  rlx_ff   <= !settled_ff[VIdxW'(eb - 8'd1)];
               end else if (e_ok && eb == EpW'(u_ff) + 8'd1) begin
                  other_ff <= VIdxW'(ea - 8'd1);
                  rlx_ff   <= !settled_ff[VIdxW'(ea - 8'd1)];
               end else begin
                  rlx_ff   <= 1'b0;
               end
               nd_ff    <= (sum > (TabW+1)'(DistSat)) ? DistSat : sum[TabW-1:0];
               state_ff <= S_DREAD;
            end
            S_DREAD: state_ff <= S_DWRITE;
            S_DWRITE: begin
               eidx_ff  <= eidx_ff + (EIdxW+1)'(1);
               state_ff <= S_EREAD;
            end
            S_OREAD: begin
               // past the last vertex: the held result leaves as the final one
               if (idx_ff >= n_ff) begin
                  pend_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_OWAIT;
               end
            end
            S_OWAIT: state_ff <= S_OEMIT;
            S_OEMIT: begin
               // hold one result back so the last one can be flagged
               if (report_ok) begin
                  pend_ff   <= 1'b1;
                  pend_v_ff <= idx_ff + 7'd1;
                  pend_d_ff <= dist_rd_ff[DistW-1:0];
               end
               idx_ff <= idx_ff + 7'd1;
               if (idx_ff + 7'd1 >= n_ff && !report_ok) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_OREAD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `DSP_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid && !rsp_last_result, busy)
   `DSP_ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_last_result, !rsp_valid)
   `DSP_ASSERT_IMPL(a_fill_max, clock, reset, 1'b1, fill_ff <= FillW'(MaxEdges))
   `DSP_ASSERT_NEXT(a_dwrite_lower, clock, reset, dwe && state_ff == S_DWRITE, dist_mem[$past(dwa)] < DistNone)
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the shortest path unit: directed table, then random phases.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import dsp_pkg::*;

   typedef struct packed {
      logic [VtxW-1:0]  vertex;
      logic [DistW-1:0] span;
      logic             last;
   } dist_report_t;

   typedef enum logic {RowCsr, RowItem} row_kind_t;

   typedef struct {
      row_kind_t       kind;
      logic            cmd;
      logic [EpW-1:0]  a;
      logic [EpW-1:0]  b;
      logic [WgtW-1:0] w;
      logic [0:0]      idx;
      logic [VtxW-1:0] val;
      int              n_reports;  // -1: left to the predictor alone
   } plan_row_t;

   localparam int IdleLimit = 1000000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic            req_command = CmdAdd;
   logic [EpW-1:0]  req_endpoint_a = '0;
   logic [EpW-1:0]  req_endpoint_b = '0;
   logic [WgtW-1:0] req_edge_weight = '0;
   logic            rsp_valid;
   logic [VtxW-1:0] rsp_vertex_number;
   logic [DistW-1:0] rsp_path_distance;
   logic            rsp_last_result;
   logic            csr_write = 1'b0;
   logic [0:0]      csr_index = CsrVertexCount;
   logic [VtxW-1:0] csr_data = '0;

   dijkstra_shortest_paths_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state
   logic [EpW-1:0]  graph_a [MaxEdges];
   logic [EpW-1:0]  graph_b [MaxEdges];
   logic [WgtW-1:0] graph_w [MaxEdges];
   int              graph_fill = 0;
   logic [VtxW-1:0] vertex_total = 7'd64;
   logic [VtxW-1:0] source_vertex = 7'd1;
   dist_report_t    pending_reports [$];

   int errors = 0;
   int items_sent = 0;
   int runs_sent = 0;
   int reports_seen = 0;
   int idle_cycles = 0;
   bit idling_on = 1'b1;

   function automatic int live_vertices();
      return (vertex_total > MaxVertices) ? MaxVertices : int'(vertex_total);
   endfunction

   function automatic void store_edge(logic [EpW-1:0] a, logic [EpW-1:0] b,
                                      logic [WgtW-1:0] w);
      int n;
      n = live_vertices();
      if (a == 0 || b == 0 || a > n || b > n || graph_fill >= MaxEdges) return;
      graph_a[graph_fill] = a;
      graph_b[graph_fill] = b;
      graph_w[graph_fill] = w;
      graph_fill++;
   endfunction

   // Settle vertices in order of least distance, lower number on ties.
   function automatic int predict_distances();
      int n, s, u, other, cnt;
      int unsigned nd;
      logic [TabW-1:0] dist_tab [MaxVertices];
      bit done [MaxVertices];
      logic [TabW-1:0] best;
      dist_report_t rep;
      n = live_vertices();
      s = source_vertex;
      cnt = 0;
      if (s == 0 || s > n) return 0;
      for (int i = 0; i < MaxVertices; i++) begin
         dist_tab[i] = DistNone;
         done[i] = 1'b0;
      end
      dist_tab[s-1] = '0;
      forever begin
         best = DistNone;
         u = MaxVertices;
         for (int i = 0; i < n; i++)
            if (!done[i] && dist_tab[i] < best) begin
               best = dist_tab[i];
               u = i;
            end
         if (u == MaxVertices) break;
         done[u] = 1'b1;
         for (int e = 0; e < graph_fill; e++) begin
            if (graph_a[e] > n || graph_b[e] > n) continue;
            if (graph_a[e] == u + 1) other = graph_b[e] - 1;
            else if (graph_b[e] == u + 1) other = graph_a[e] - 1;
            else continue;
            if (done[other]) continue;
            nd = best + graph_w[e];
            if (nd > DistSat) nd = DistSat;
            if (nd < dist_tab[other]) dist_tab[other] = nd;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (i == s - 1 || dist_tab[i] == DistNone) continue;
         rep.vertex = VtxW'(i + 1);
         rep.span = dist_tab[i][DistW-1:0];
         rep.last = 1'b0;
         pending_reports.push_back(rep);
         cnt++;
      end
      if (cnt > 0) pending_reports[$].last = 1'b1;
      return cnt;
   endfunction

   // Result checker and watchdog
   always @(posedge clock) begin
      dist_report_t want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("dijkstra_shortest_paths_unit verification failed");
            $finish;
         end
         if (rsp_valid) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
               $error("unexpected result vertex %0d", rsp_vertex_number);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_vertex_number !== want.vertex) begin
                  $error("vertex_number expected %0d got %0d", want.vertex,
                         rsp_vertex_number);
                  errors++;
               end
               if (rsp_path_distance !== want.span) begin
                  $error("path_distance expected %0d got %0d", want.span,
                         rsp_path_distance);
                  errors++;
               end
               if (rsp_last_result !== want.last) begin
                  $error("last_result expected %0d got %0d", want.last,
                         rsp_last_result);
                  errors++;
               end
            end
         end
      end
   end

   // Hold the item until the transfer, then predict. Called at a falling edge.
   task automatic send_item(logic cmd, logic [EpW-1:0] a, logic [EpW-1:0] b,
                            logic [WgtW-1:0] w, output int n_rep);
      start = 1'b1;
      req_command = cmd;
      req_endpoint_a = a;
      req_endpoint_b = b;
      req_edge_weight = w;
      do @(posedge clock); while (busy);
      items_sent++;
      n_rep = 0;
      if (cmd == CmdRun) begin
         runs_sent++;
         n_rep = predict_distances();
      end else begin
         store_edge(a, b, w);
      end
      @(negedge clock);
      start = 1'b0;
      if (idling_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (busy || pending_reports.size() != 0);
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [VtxW-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CsrVertexCount) vertex_total = val;
      else source_vertex = val;
   endtask

   plan_row_t plan [24] = '{
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrVertexCount, 3,   -1},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrStartVertex, 1,   -1},
      '{RowItem, CmdRun, 0,   0,   0,     CsrVertexCount, 0,    0},
      '{RowItem, CmdAdd, 1,   2,   65535, CsrVertexCount, 0,   -1},
      '{RowItem, CmdAdd, 2,   3,   65535, CsrVertexCount, 0,   -1},
      '{RowItem, CmdAdd, 3,   3,   0,     CsrVertexCount, 0,   -1},
      '{RowItem, CmdAdd, 0,   1,   5,     CsrVertexCount, 0,   -1},
      '{RowItem, CmdAdd, 1,   4,   7,     CsrVertexCount, 0,   -1},
      '{RowItem, CmdAdd, 255, 255, 65535, CsrVertexCount, 0,   -1},
      '{RowItem, CmdRun, 255, 255, 65535, CsrVertexCount, 0,    2},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrStartVertex, 3,   -1},
      '{RowItem, CmdRun, 0,   0,   0,     CsrVertexCount, 0,    2},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrStartVertex, 0,   -1},
      '{RowItem, CmdRun, 0,   0,   0,     CsrVertexCount, 0,    0},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrVertexCount, 0,   -1},
      '{RowItem, CmdRun, 0,   0,   0,     CsrVertexCount, 0,    0},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrVertexCount, 127, -1},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrStartVertex, 64,  -1},
      '{RowItem, CmdAdd, 64,  1,   0,     CsrVertexCount, 0,   -1},
      '{RowItem, CmdRun, 0,   0,   0,     CsrVertexCount, 0,    3},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrVertexCount, 2,   -1},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrStartVertex, 2,   -1},
      '{RowItem, CmdRun, 0,   0,   0,     CsrVertexCount, 0,    1},
      '{RowCsr,  CmdAdd, 0,   0,   0,     CsrVertexCount, 64,  -1}
   };

   initial begin
      int n_rep, n, runs_left;
      logic [EpW-1:0] a, b;
      logic [WgtW-1:0] w;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == RowCsr) begin
            wait_idle();
            write_csr(plan[i].idx, plan[i].val);
         end else begin
            send_item(plan[i].cmd, plan[i].a, plan[i].b, plan[i].w, n_rep);
            if (plan[i].n_reports >= 0 && n_rep != plan[i].n_reports) begin
               $error("report count expected %0d got %0d", plan[i].n_reports, n_rep);
               errors++;
            end
         end
      end

      for (int p = 0; p < 12; p++) begin
         idling_on = (p < 10);
         wait_idle();
         case ($urandom_range(0, 9))
            0:       write_csr(CsrVertexCount, 7'd64);
            1:       write_csr(CsrVertexCount, 7'd0);
            2:       write_csr(CsrVertexCount, VtxW'($urandom_range(65, 127)));
            default: write_csr(CsrVertexCount, VtxW'($urandom_range(2, 12)));
         endcase
         n = live_vertices();
         if ($urandom_range(0, 7) == 0 || n == 0)
            write_csr(CsrStartVertex, VtxW'($urandom_range(0, 127)));
         else
            write_csr(CsrStartVertex, VtxW'($urandom_range(1, n)));
         // wide graphs make slow runs: allow only one there
         runs_left = (n > 16) ? 1 : 4;
         for (int k = 0; k < 40; k++) begin
            if (k == 39 || (runs_left > 1 && $urandom_range(0, 9) == 0)) begin
               runs_left--;
               send_item(CmdRun, EpW'($urandom), EpW'($urandom), WgtW'($urandom),
                         n_rep);
               continue;
            end
            if (n == 0 || $urandom_range(0, 5) == 0) begin
               a = EpW'($urandom);
               b = EpW'($urandom);
            end else begin
               a = EpW'($urandom_range(1, n));
               b = EpW'($urandom_range(1, n));
            end
            case ($urandom_range(0, 7))
               0:       w = '0;
               1:       w = '1;
               default: w = WgtW'($urandom);
            endcase
            send_item(CmdAdd, a, b, w, n_rep);
         end
      end

      wait_idle();
      repeat (20) @(negedge clock);
      $display("Sent %0d items including %0d searches; checked %0d distance reports.",
               items_sent, runs_sent, reports_seen);
      $display("Edge store ended with %0d of %0d entries filled.", graph_fill, MaxEdges);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("dijkstra_shortest_paths_unit verification clean");
      end else begin
         if (pending_reports.size() != 0)
            $error("%0d expected results never arrived", pending_reports.size());
         $display("dijkstra_shortest_paths_unit verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
